// ----- design/rth_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared widths, constants, beat structures and the divider step used by the
// pixel conversion pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

  // Field widths.
  localparam int PIX_W = 8;
  localparam int HUE_W = 9;
  localparam int DIVIDEND_W = 2 * PIX_W;
  localparam int HUE_PROD_W = PIX_W + 6;

  // Long division: one quotient bit per step, two steps per stage.
  localparam int DIV_STEPS = 2;
  localparam int DIV_STAGES = PIX_W / DIV_STEPS;

  // Sector base angles in degrees.
  localparam logic [HUE_W-1:0] HUE_BASE_ZERO = 9'd0;
  localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 9'd120;
  localparam logic [HUE_W-1:0] HUE_BASE_BLUE = 9'd240;
  localparam logic [HUE_W-1:0] HUE_BASE_WRAP = 9'd360;

  // Channel that holds the maximum, first match in red, green, blue order.
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // Beat between the two front stages.
  typedef struct packed {
    logic [PIX_W-1:0]        max_val;
    logic [PIX_W-1:0]        min_val;
    sector_t                 sector;
    logic signed [PIX_W:0]   diff;
  } front_beat_t;

  // One restoring divider lane.
  typedef struct packed {
    logic [PIX_W-1:0] part;
    logic [PIX_W-1:0] num;
    logic [PIX_W-1:0] den;
    logic [PIX_W-1:0] quo;
  } div_lane_t;

  // Beat that travels through the divider stages.
  typedef struct packed {
    div_lane_t         hue;
    div_lane_t         sat;
    logic [HUE_W-1:0]  base;
    logic              neg;
    logic              grey;
    logic [PIX_W-1:0]  val;
  } div_beat_t;

  // One step of long division: bring down the next dividend bit and subtract
  // the divisor when it fits.
  function automatic div_lane_t div_step(div_lane_t lane_in);
    div_lane_t      lane;
    logic [PIX_W:0] cand;
    lane = lane_in;
    cand = {lane_in.part, lane_in.num[PIX_W-1]};
    lane.num = {lane_in.num[PIX_W-2:0], 1'b0};
    if (cand >= {1'b0, lane_in.den}) begin
      lane.part = PIX_W'(cand - {1'b0, lane_in.den});
      lane.quo = {lane_in.quo[PIX_W-2:0], 1'b1};
    end else begin
      lane.part = cand[PIX_W-1:0];
      lane.quo = {lane_in.quo[PIX_W-2:0], 1'b0};
    end
    return lane;
  endfunction

endpackage

// ----- design/rth_in_if.sv -----
// ----------------------------------------------------------------------------
// RGB pixel channel
// Valid/ready channel that carries one RGB pixel per beat.
// ----------------------------------------------------------------------------
interface rth_in_if;
  import rth_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ----- design/rth_out_if.sv -----
// ----------------------------------------------------------------------------
// HSV pixel channel
// Valid/ready channel that carries one HSV result per beat.
// ----------------------------------------------------------------------------
interface rth_out_if;
  import rth_pkg::*;

  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue_degrees;
  logic [PIX_W-1:0] sat_scaled;
  logic [PIX_W-1:0] val_level;

  modport source (output valid, output hue_degrees, output sat_scaled, output val_level,
                  input ready);
  modport sink (input valid, input hue_degrees, input sat_scaled, input val_level,
                output ready);
endinterface

// ----- design/rgb_to_hsv_pixel.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter
// Streams 8-bit RGB pixels in and HSV results out, one pixel per clock unless out_hsv stalls.
// ----------------------------------------------------------------------------
// Usage:
// in_pix carries one RGB pixel per beat; out_hsv carries the matching hue in
// whole degrees (0..359), saturation floor(255*delta/max) and value (max).
// Results leave in the order the pixels arrived, one result per pixel.
// From an accepted input beat to a valid result each pixel passes through the
// two front stages, four divider stages and the output register.
// Throughput is one pixel per cycle while out_hsv.ready is high, set by the divider
// pipeline, where each of the four stages resolves two quotient bits of both dividers.
// Every stage holds its beat when the next one is full and stalled, and takes
// a new beat into any empty slot, so in_pix.ready stays high while bubbles
// remain even if out_hsv.ready is low. With out_hsv.ready high, in_pix.ready
// is high as well. After a full stall the pipeline holds seven pixels.
// Synchronous reset clears all stage valid bits; no result is presented until
// a new pixel has passed through. The block holds no configuration or state
// between pixels.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel (
  input  logic      clk,
  input  logic      rst_n,
  rth_in_if.sink    in_pix,
  rth_out_if.source out_hsv
);
  import rth_pkg::*;

  logic                 valid_s [DIV_STAGES+1];
  logic                 ready_s [DIV_STAGES+1];
  div_beat_t            beat_s  [DIV_STAGES+1];

  // Front end: max, min, sector and dividends.
  rth_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_pix.valid),
    .ready_o (in_pix.ready),
    .red_i   (in_pix.red),
    .green_i (in_pix.green),
    .blue_i  (in_pix.blue),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .beat_o  (beat_s[0])
  );

  // Divider pipeline for hue and saturation.
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    rth_div_stage u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_s[i]),
      .ready_o (ready_s[i]),
      .beat_i  (beat_s[i]),
      .valid_o (valid_s[i+1]),
      .ready_i (ready_s[i+1]),
      .beat_o  (beat_s[i+1])
    );
  end

  // Output register with hue correction.
  rth_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (valid_s[DIV_STAGES]),
    .ready_o (ready_s[DIV_STAGES]),
    .beat_i  (beat_s[DIV_STAGES]),
    .valid_o (out_hsv.valid),
    .ready_i (out_hsv.ready),
    .hue_o   (out_hsv.hue_degrees),
    .sat_o   (out_hsv.sat_scaled),
    .val_o   (out_hsv.val_level)
  );

  // Hue never reaches a full turn.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_hsv.valid |-> (out_hsv.hue_degrees < HUE_BASE_WRAP))
    else $error("hue out of range");

  // Zero saturation means a grey pixel, whose hue is zero.
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_hsv.valid && (out_hsv.sat_scaled == '0)) |-> (out_hsv.hue_degrees == '0))
    else $error("grey pixel with nonzero hue");

  // A draining output lets the whole pipeline advance.
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_hsv.ready |-> in_pix.ready)
    else $error("input stalled while output drains");

  // After an accepted pixel the front stage is ready again in the next cycle
  // whenever the output drains.
  a_front_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |=> u_front.ready_o || !out_hsv.ready)
    else $error("front stage full while output drains");

endmodule

// ----- design/rth_front.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Two pipeline stages: maximum, minimum and sector, then delta, the scaled
// dividends and the sector base that load the divider lanes.
// ----------------------------------------------------------------------------
module rth_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [rth_pkg::PIX_W-1:0] red_i,
  input  logic [rth_pkg::PIX_W-1:0] green_i,
  input  logic [rth_pkg::PIX_W-1:0] blue_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output rth_pkg::div_beat_t      beat_o
);
  import rth_pkg::*;

  logic              a_valid_r;
  logic              a_ready;
  front_beat_t       a_beat_r;
  front_beat_t       a_beat_nxt;
  logic              b_valid_r;
  div_beat_t         b_beat_r;
  div_beat_t         b_beat_nxt;
  logic [PIX_W-1:0]  rg_max;
  logic [PIX_W-1:0]  rg_min;
  logic [PIX_W-1:0]  delta;
  logic [PIX_W-1:0]  abs_diff;
  logic [HUE_PROD_W-1:0] hue_prod;
  logic [DIVIDEND_W-1:0] hue_dividend;
  logic [DIVIDEND_W-1:0] sat_dividend;

  // A stage takes a beat when it is empty or its beat moves on.
  assign ready_o = !a_valid_r || a_ready;
  assign a_ready = !b_valid_r || ready_i;

  // Stage A: maximum, minimum, sector and signed channel difference.
  always_comb begin
    rg_max = (red_i > green_i) ? red_i : green_i;
    rg_min = (red_i < green_i) ? red_i : green_i;
    a_beat_nxt.max_val = (rg_max > blue_i) ? rg_max : blue_i;
    a_beat_nxt.min_val = (rg_min < blue_i) ? rg_min : blue_i;
    if (red_i == a_beat_nxt.max_val) begin
      a_beat_nxt.sector = SECT_RED;
      a_beat_nxt.diff = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i == a_beat_nxt.max_val) begin
      a_beat_nxt.sector = SECT_GREEN;
      a_beat_nxt.diff = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      a_beat_nxt.sector = SECT_BLUE;
      a_beat_nxt.diff = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (ready_o) begin
      a_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      a_beat_r <= a_beat_nxt;
    end
  end

  // Stage B: delta, magnitude of the difference and both dividends.
  always_comb begin
    delta = a_beat_r.max_val - a_beat_r.min_val;
    b_beat_nxt.neg = a_beat_r.diff[PIX_W];
    abs_diff = b_beat_nxt.neg ? PIX_W'(-a_beat_r.diff) : a_beat_r.diff[PIX_W-1:0];
    // 60 * |diff| as 64x - 4x.
    hue_prod = {abs_diff, 6'b0} - {4'b0, abs_diff, 2'b0};
    hue_dividend = {{(DIVIDEND_W-HUE_PROD_W){1'b0}}, hue_prod};
    // 255 * delta as 256x - x.
    sat_dividend = {delta, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, delta};
    case (a_beat_r.sector)
      SECT_RED:   b_beat_nxt.base = b_beat_nxt.neg ? HUE_BASE_WRAP : HUE_BASE_ZERO;
      SECT_GREEN: b_beat_nxt.base = HUE_BASE_GREEN;
      SECT_BLUE:  b_beat_nxt.base = HUE_BASE_BLUE;
      default:    b_beat_nxt.base = HUE_BASE_ZERO;
    endcase
    b_beat_nxt.grey = (delta == '0);
    b_beat_nxt.val = a_beat_r.max_val;
    b_beat_nxt.hue.part = hue_dividend[DIVIDEND_W-1:PIX_W];
    b_beat_nxt.hue.num = hue_dividend[PIX_W-1:0];
    b_beat_nxt.hue.den = delta;
    b_beat_nxt.hue.quo = '0;
    b_beat_nxt.sat.part = sat_dividend[DIVIDEND_W-1:PIX_W];
    b_beat_nxt.sat.num = sat_dividend[PIX_W-1:0];
    b_beat_nxt.sat.den = a_beat_r.max_val;
    b_beat_nxt.sat.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r && a_ready) begin
      b_beat_r <= b_beat_nxt;
    end
  end

  assign valid_o = b_valid_r;
  assign beat_o = b_beat_r;

endmodule

// ----- design/rth_div_stage.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV divider stage
// One register stage of the two long dividers; each stage resolves two
// quotient bits of both the hue and the saturation lane.
// ----------------------------------------------------------------------------
module rth_div_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  output logic               ready_o,
  input  rth_pkg::div_beat_t beat_i,
  output logic               valid_o,
  input  logic               ready_i,
  output rth_pkg::div_beat_t beat_o
);
  import rth_pkg::*;

  logic      valid_r;
  div_beat_t beat_r;
  div_beat_t beat_nxt;

  assign ready_o = !valid_r || ready_i;

  // Two dependent division steps on 8-bit lanes, each comparing a 9-bit candidate.
  always_comb begin
    beat_nxt = beat_i;
    for (int s = 0; s < DIV_STEPS; s++) begin
      beat_nxt.hue = div_step(beat_nxt.hue);
      beat_nxt.sat = div_step(beat_nxt.sat);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      beat_r <= beat_nxt;
    end
  end

  assign valid_o = valid_r;
  assign beat_o = beat_r;

endmodule

// ----- design/rth_back.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV output stage
// Applies the sector base and floor correction to the hue quotient, clears
// hue for grey pixels and saturation for black ones, and holds the result beat.
// ----------------------------------------------------------------------------
module rth_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  rth_pkg::div_beat_t         beat_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [rth_pkg::HUE_W-1:0]  hue_o,
  output logic [rth_pkg::PIX_W-1:0]  sat_o,
  output logic [rth_pkg::PIX_W-1:0]  val_o
);
  import rth_pkg::*;

  logic             valid_r;
  logic [HUE_W-1:0] hue_r;
  logic [HUE_W-1:0] hue_nxt;
  logic [PIX_W-1:0] sat_r;
  logic [PIX_W-1:0] sat_nxt;
  logic [PIX_W-1:0] val_r;
  logic [HUE_W-1:0] quo_ext;
  logic [HUE_W-1:0] rem_adj;

  assign ready_o = !valid_r || ready_i;

  // A negative difference floors downward, so a nonzero remainder costs one
  // more degree below the base.
  always_comb begin
    quo_ext = {{(HUE_W-PIX_W){1'b0}}, beat_i.hue.quo};
    rem_adj = {{(HUE_W-1){1'b0}}, (beat_i.hue.part != '0)};
    if (beat_i.grey) begin
      hue_nxt = '0;
    end else if (beat_i.neg) begin
      hue_nxt = beat_i.base - quo_ext - rem_adj;
    end else begin
      hue_nxt = beat_i.base + quo_ext;
    end
    sat_nxt = (beat_i.val == '0) ? '0 : beat_i.sat.quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      val_r <= beat_i.val;
    end
  end

  assign valid_o = valid_r;
  assign hue_o = hue_r;
  assign sat_o = sat_r;
  assign val_o = val_r;

endmodule
